/* src/etf_pkg.sv */
`timescale 1ns / 1ps

package etf_pkg;

  // Default build widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ITER_WIDTH_DEF  = 16;

  // Configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register field widths
  localparam int MAX_ITER_W = 16;
  localparam int JULIA_W    = 32;
  localparam int ESC_CNT_W  = 16;

  // Reset values
  localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd30;
  localparam logic                  MODE_RST     = 1'b0;
  localparam logic [JULIA_W-1:0]    JULIA_RE_RST = 32'hF8A3_D571;  // -0.46 in Q4.28
  localparam logic [JULIA_W-1:0]    JULIA_IM_RST = 32'h0947_AE14;  //  0.58 in Q4.28

  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_MODE     = 2'd1,
    REG_JULIA_RE = 2'd2,
    REG_JULIA_IM = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_RR,
    SEL_II,
    SEL_RI
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     step;
  } dp_ctrl_t;

  typedef struct packed {
    logic mag_gt;
    logic ovf;
  } dp_stat_t;

endpackage

/* src/etf_regs.sv */
`timescale 1ns / 1ps

module etf_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [etf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [etf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [etf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [etf_pkg::MAX_ITER_W-1:0]      max_iterations,
  output logic                                fractal_mode,
  output logic [etf_pkg::JULIA_W-1:0]         julia_re,
  output logic [etf_pkg::JULIA_W-1:0]         julia_im
);

  etf_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = etf_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= etf_pkg::MAX_ITER_RST;
      fractal_mode   <= etf_pkg::MODE_RST;
      julia_re       <= etf_pkg::JULIA_RE_RST;
      julia_im       <= etf_pkg::JULIA_IM_RST;
    end else if (wr_en) begin
      case (idx)
        etf_pkg::REG_MAX_ITER: max_iterations <= pwdata[etf_pkg::MAX_ITER_W-1:0];
        etf_pkg::REG_MODE:     fractal_mode   <= pwdata[0];
        etf_pkg::REG_JULIA_RE: julia_re       <= pwdata[etf_pkg::JULIA_W-1:0];
        etf_pkg::REG_JULIA_IM: julia_im       <= pwdata[etf_pkg::JULIA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      etf_pkg::REG_MAX_ITER: prdata = etf_pkg::CFG_DATA_W'(max_iterations);
      etf_pkg::REG_MODE:     prdata = etf_pkg::CFG_DATA_W'(fractal_mode);
      etf_pkg::REG_JULIA_RE: prdata = etf_pkg::CFG_DATA_W'(julia_re);
      etf_pkg::REG_JULIA_IM: prdata = etf_pkg::CFG_DATA_W'(julia_im);
      default:               prdata = '0;
    endcase
  end

endmodule

/* src/etf_dp.sv */
`timescale 1ns / 1ps

module etf_dp #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic signed [COORD_WIDTH-1:0]     point_re,
  input  logic signed [COORD_WIDTH-1:0]     point_im,
  input  logic                              fractal_mode,
  input  logic [etf_pkg::JULIA_W-1:0]       julia_re,
  input  logic [etf_pkg::JULIA_W-1:0]       julia_im,
  input  etf_pkg::dp_ctrl_t                 ctrl,
  output etf_pkg::dp_stat_t                 stat
);

  localparam int CW     = COORD_WIDTH;
  localparam int FRAC   = CW - 4;
  localparam int PW     = 2 * CW;
  localparam int SUM_W  = CW + 6;
  localparam logic [PW:0] MAG_LIMIT = (PW + 1)'(1) << (2 * FRAC + 2);

  logic signed [CW-1:0]    zre, zim, cre, cim;
  logic signed [PW-1:0]    rr, ii, ri;
  logic signed [CW-1:0]    op_a, op_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW:0]      diff;
  logic signed [SUM_W-1:0] nre_w, nim_w;
  logic [PW:0]             mag;
  logic                    re_fits, im_fits;

  // Shared multiplier: one product per cycle, operands picked by the sequencer
  always_comb begin
    case (ctrl.mul_sel)
      etf_pkg::SEL_RR: begin
        op_a = zre;
        op_b = zre;
      end
      etf_pkg::SEL_II: begin
        op_a = zim;
        op_b = zim;
      end
      etf_pkg::SEL_RI: begin
        op_a = zre;
        op_b = zim;
      end
      default: begin
        op_a = zre;
        op_b = zim;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // z*z + c with floor shifts; widths keep every value exact
  assign diff  = (PW + 1)'(rr) - (PW + 1)'(ii);
  assign nre_w = SUM_W'($signed(diff[PW:FRAC])) + SUM_W'(cre);
  assign nim_w = SUM_W'($signed(ri[PW-1:FRAC-1])) + SUM_W'(cim);

  assign re_fits = (nre_w[SUM_W-1:CW-1] == '0) || (nre_w[SUM_W-1:CW-1] == '1);
  assign im_fits = (nim_w[SUM_W-1:CW-1] == '0) || (nim_w[SUM_W-1:CW-1] == '1);

  // Both squares are non-negative here
  assign mag = {1'b0, rr} + {1'b0, ii};

  assign stat.mag_gt = mag > MAG_LIMIT;
  assign stat.ovf    = !(re_fits && im_fits);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (fractal_mode) begin
        zre <= point_re;
        zim <= point_im;
        cre <= CW'(julia_re);
        cim <= CW'(julia_im);
      end else begin
        zre <= '0;
        zim <= '0;
        cre <= point_re;
        cim <= point_im;
      end
    end else if (ctrl.step) begin
      zre <= nre_w[CW-1:0];
      zim <= nim_w[CW-1:0];
    end

    if (ctrl.mul_en) begin
      case (ctrl.mul_sel)
        etf_pkg::SEL_RR: rr <= prod;
        etf_pkg::SEL_II: ii <= prod;
        etf_pkg::SEL_RI: ri <= prod;
        default: ;
      endcase
    end
  end

endmodule

/* src/etf_ctrl.sv */
`timescale 1ns / 1ps

module etf_ctrl #(
  parameter int ITER_WIDTH = etf_pkg::ITER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res,
  output logic [etf_pkg::ESC_CNT_W-1:0]     escape_count,
  input  logic [etf_pkg::MAX_ITER_W-1:0]    max_iterations,
  input  etf_pkg::dp_stat_t                 stat,
  output etf_pkg::dp_ctrl_t                 ctrl
);

  localparam int CNT_W = (ITER_WIDTH < etf_pkg::MAX_ITER_W) ? ITER_WIDTH : etf_pkg::MAX_ITER_W;

  etf_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] n, n_next;
  logic             tested, tested_next;
  logic [CNT_W-1:0] limit;
  logic             fin, fin_inside;
  logic [CNT_W-1:0] fin_count;
  logic             res_inside;
  logic [CNT_W-1:0] res_count;
  logic             out_load;

  assign limit    = max_iterations[CNT_W-1:0];
  assign in_ready = (state == etf_pkg::ST_IDLE);
  assign out_load = (state == etf_pkg::ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next  = state;
    n_next      = n;
    tested_next = tested;
    fin         = 1'b0;
    fin_inside  = 1'b0;
    fin_count   = '0;
    ctrl        = '{load: 1'b0, mul_en: 1'b0, mul_sel: etf_pkg::SEL_RR, step: 1'b0};

    case (state)
      etf_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.load   = 1'b1;
          n_next      = '0;
          tested_next = 1'b0;
          state_next  = etf_pkg::ST_MUL_RR;
        end
      end
      etf_pkg::ST_MUL_RR: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = etf_pkg::SEL_RR;
        state_next   = etf_pkg::ST_MUL_II;
      end
      etf_pkg::ST_MUL_II: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = etf_pkg::SEL_II;
        state_next   = etf_pkg::ST_MUL_RI;
      end
      etf_pkg::ST_MUL_RI: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = etf_pkg::SEL_RI;
        // squares of the last stepped z are ready: test the magnitude first
        if (tested && stat.mag_gt) begin
          fin        = 1'b1;
          fin_count  = n - CNT_W'(1);
          state_next = etf_pkg::ST_DONE;
        end else if (n == limit) begin
          fin        = 1'b1;
          fin_inside = 1'b1;
          state_next = etf_pkg::ST_DONE;
        end else begin
          state_next = etf_pkg::ST_UPDATE;
        end
      end
      etf_pkg::ST_UPDATE: begin
        if (stat.ovf) begin
          fin        = 1'b1;
          fin_count  = n;
          state_next = etf_pkg::ST_DONE;
        end else begin
          ctrl.step   = 1'b1;
          n_next      = n + CNT_W'(1);
          tested_next = 1'b1;
          state_next  = etf_pkg::ST_MUL_RR;
        end
      end
      etf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = etf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = etf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= etf_pkg::ST_IDLE;
      n      <= '0;
      tested <= 1'b0;
    end else begin
      state  <= state_next;
      n      <= n_next;
      tested <= tested_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      res_inside <= fin_inside;
      res_count  <= fin_count;
    end
  end

  // Output register: hold the transaction until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inside_res   <= res_inside;
      escape_count <= etf_pkg::ESC_CNT_W'(res_count);
    end
  end

endmodule

/* src/escape_time_fractal_iteration.sv */
`timescale 1ns / 1ps

// Escape-time iterator for Mandelbrot and Julia sets on signed Q4.28 points
// (COORD_WIDTH bits, four integer bits). One point is in flight at a time:
// in_ready is high only while the block is idle. A single shared signed
// COORD_WIDTH x COORD_WIDTH multiplier produces one product per cycle, and
// each iteration step needs three of them (re*re, im*im, re*im) in the states
// ST_MUL_RR, ST_MUL_II and ST_MUL_RI, then ST_UPDATE forms the new z. The
// result waits in its own register, so the next point can be accepted
// while the previous result is still pending. The user must write configuration
// through the APB port only while the block is idle; the block does not enforce it.
module escape_time_fractal_iteration #(
  parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
  parameter int ITER_WIDTH  = etf_pkg::ITER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [etf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [etf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [etf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     point_re,
  input  logic signed [COORD_WIDTH-1:0]     point_im,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res,
  output logic [etf_pkg::ESC_CNT_W-1:0]     escape_count
);

  logic [etf_pkg::MAX_ITER_W-1:0] max_iterations;
  logic                           fractal_mode;
  logic [etf_pkg::JULIA_W-1:0]    julia_re;
  logic [etf_pkg::JULIA_W-1:0]    julia_im;
  etf_pkg::dp_ctrl_t              dp_ctrl;
  etf_pkg::dp_stat_t              dp_stat;

  etf_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .max_iterations (max_iterations),
    .fractal_mode   (fractal_mode),
    .julia_re       (julia_re),
    .julia_im       (julia_im)
  );

  etf_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .point_re     (point_re),
    .point_im     (point_im),
    .fractal_mode (fractal_mode),
    .julia_re     (julia_re),
    .julia_im     (julia_im),
    .ctrl         (dp_ctrl),
    .stat         (dp_stat)
  );

  etf_ctrl #(
    .ITER_WIDTH (ITER_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .inside_res     (inside_res),
    .escape_count   (escape_count),
    .max_iterations (max_iterations),
    .stat           (dp_stat),
    .ctrl           (dp_ctrl)
  );

endmodule

/* src/etf_checker.sv */
`timescale 1ns / 1ps

module etf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           inside_res,
  input logic [etf_pkg::ESC_CNT_W-1:0]  escape_count
);

  // A pending result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res) && $stable(escape_count))
    else $error("result dropped or changed while stalled");

  // Nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Inside points always report a zero count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> escape_count == '0)
    else $error("inside point with nonzero count");

  // The block is busy, with in_ready low, after taking a point
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("point accepted while iteration still running");

endmodule

bind escape_time_fractal_iteration etf_checker u_etf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .inside_res   (inside_res),
  .escape_count (escape_count)
);

/* sim/tb_escape_time_fractal_iteration.sv */
`timescale 1ns / 1ps

module tb_escape_time_fractal_iteration;

  localparam int FRAC_BITS = etf_pkg::COORD_WIDTH_DEF - 4;
  localparam logic [31:0] ONE_Q = 32'h1000_0000;

  typedef logic signed [etf_pkg::COORD_WIDTH_DEF-1:0] coord_t;

  typedef struct {
    logic                          in_set;
    logic [etf_pkg::ESC_CNT_W-1:0] count;
  } escape_result_t;

  class escape_scoreboard;
    escape_result_t                     expected_q[$];
    logic [etf_pkg::MAX_ITER_W-1:0]     iter_limit;
    logic                               julia_mode;
    logic signed [etf_pkg::JULIA_W-1:0] c_re;
    logic signed [etf_pkg::JULIA_W-1:0] c_im;
    int points_seen;
    int results_seen;
    int mismatches;

    function new();
      iter_limit = etf_pkg::MAX_ITER_RST;
      julia_mode = etf_pkg::MODE_RST;
      c_re = etf_pkg::JULIA_RE_RST;
      c_im = etf_pkg::JULIA_IM_RST;
    endfunction

    function void set_reg(etf_pkg::reg_idx_t idx, logic [etf_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        etf_pkg::REG_MAX_ITER: iter_limit = v[etf_pkg::MAX_ITER_W-1:0];
        etf_pkg::REG_MODE:     julia_mode = v[0];
        etf_pkg::REG_JULIA_RE: c_re = v[etf_pkg::JULIA_W-1:0];
        etf_pkg::REG_JULIA_IM: c_im = v[etf_pkg::JULIA_W-1:0];
        default: ;
      endcase
    endfunction

    // Iterate z = z*z + c with exact products and floor shifts.
    function void note_point(coord_t re, coord_t im);
      logic signed [127:0] zr, zi, cr, ci, nr, ni;
      logic signed [127:0] cmax, cmin, thr;
      escape_result_t res;
      logic escaped;
      int n;
      cmax = (128'sd1 <<< (etf_pkg::COORD_WIDTH_DEF - 1)) - 128'sd1;
      cmin = -(128'sd1 <<< (etf_pkg::COORD_WIDTH_DEF - 1));
      thr = 128'sd4 <<< (2 * FRAC_BITS);
      if (julia_mode) begin
        zr = 128'(re);
        zi = 128'(im);
        cr = 128'(c_re);
        ci = 128'(c_im);
      end else begin
        zr = '0;
        zi = '0;
        cr = 128'(re);
        ci = 128'(im);
      end
      res.in_set = 1'b1;
      res.count = '0;
      escaped = 1'b0;
      for (n = 0; n < int'(iter_limit) && !escaped; n++) begin
        nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
        ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
        if (nr > cmax || nr < cmin || ni > cmax || ni < cmin) begin
          escaped = 1'b1;
        end else begin
          zr = nr;
          zi = ni;
          escaped = (zr * zr + zi * zi) > thr;
        end
        if (escaped) begin
          res.in_set = 1'b0;
          res.count = n[etf_pkg::ESC_CNT_W-1:0];
        end
      end
      expected_q.push_back(res);
      points_seen++;
    endfunction

    function void check_result(logic in_set, logic [etf_pkg::ESC_CNT_W-1:0] count);
      escape_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending (inside_res %0b, escape_count %0d)",
                 $time, in_set, count);
        mismatches++;
      end else begin
        exp_res = expected_q.pop_front();
        if (in_set !== exp_res.in_set) begin
          $display("%0t: inside_res expected %0b got %0b", $time, exp_res.in_set, in_set);
          mismatches++;
        end
        if (count !== exp_res.count) begin
          $display("%0t: escape_count expected %0d got %0d", $time, exp_res.count, count);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [etf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [etf_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [etf_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  coord_t                         point_re = '0;
  coord_t                         point_im = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           inside_res;
  logic [etf_pkg::ESC_CNT_W-1:0]  escape_count;

  escape_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int settings_count = 0;
  int send_idle_by_phase[4] = '{0, 82, 0, 22};
  int recv_stall_by_phase[4] = '{0, 0, 82, 22};

  escape_time_fractal_iteration dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .point_re(point_re),
    .point_im(point_im),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res),
    .escape_count(escape_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(inside_res, escape_count);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(coord_t re, coord_t im);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      point_re <= $urandom;
      point_im <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    point_re <= re;
    point_im <= im;
    do @(posedge clk); while (!in_ready);
    sb.note_point(re, im);
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(etf_pkg::reg_idx_t idx, logic [etf_pkg::CFG_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [etf_pkg::MAX_ITER_W-1:0] iters, logic mode,
                                logic [etf_pkg::JULIA_W-1:0] jre,
                                logic [etf_pkg::JULIA_W-1:0] jim);
    wait_drained();
    write_reg(etf_pkg::REG_MAX_ITER, etf_pkg::CFG_DATA_W'(iters));
    write_reg(etf_pkg::REG_MODE, etf_pkg::CFG_DATA_W'(mode));
    write_reg(etf_pkg::REG_JULIA_RE, etf_pkg::CFG_DATA_W'(jre));
    write_reg(etf_pkg::REG_JULIA_IM, etf_pkg::CFG_DATA_W'(jim));
    settings_count++;
  endtask

  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(7))
      0: v = $urandom;
      1: v = $urandom_range(0, 134217728) - 32'd67108864;
      default: v = $urandom_range(0, 1181116006) - 32'd590558003;
    endcase
    return v;
  endfunction

  initial begin
    int ph;
    int blk;
    int k;
    logic [etf_pkg::MAX_ITER_W-1:0] iters;
    logic [etf_pkg::JULIA_W-1:0] jre;
    logic [etf_pkg::JULIA_W-1:0] jim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: Mandelbrot, 30 steps.
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hE000_0000, 32'h0000_0000);  // c = -2 sits exactly on |z| = 2
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0400_0000, 32'h0000_0000);
    send_point(32'hF400_0000, 32'h0199_999A);
    send_point(32'h04CC_CCCD, 32'h0800_0000);
    send_point(ONE_Q, 32'h0000_0000);

    apply_settings(16'd30, 1'b1, etf_pkg::JULIA_RE_RST, etf_pkg::JULIA_IM_RST);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h0000_0000);  // square overflows on the first step
    send_point(32'h8000_0000, 32'h0000_0000);
    send_point(32'h0199_999A, 32'h0199_999A);
    send_point(32'hF800_0000, 32'h0800_0000);

    // Starting z is outside radius 2 but is never tested itself.
    apply_settings(16'd30, 1'b1, 32'h468F_5C29, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h2199_999A);

    apply_settings(16'd0, 1'b0, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    apply_settings(16'd1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);

    apply_settings(16'hFFFF, 1'b0, etf_pkg::JULIA_RE_RST, etf_pkg::JULIA_IM_RST);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(ONE_Q, ONE_Q);

    for (ph = 0; ph < 4; ph++) begin
      for (blk = 0; blk < 4; blk++) begin
        case ($urandom_range(15))
          0: iters = 16'd0;
          1: iters = 16'd1;
          2: iters = 16'd2;
          3: iters = etf_pkg::MAX_ITER_W'($urandom_range(100, 255));
          default: iters = etf_pkg::MAX_ITER_W'($urandom_range(3, 48));
        endcase
        if ($urandom_range(3) == 0) begin
          jre = $urandom;
          jim = $urandom;
        end else begin
          jre = $urandom_range(0, 2 * ONE_Q) - ONE_Q;
          jim = $urandom_range(0, 2 * ONE_Q) - ONE_Q;
        end
        apply_settings(iters, 1'($urandom_range(1)), jre, jim);
        send_idle_pct = send_idle_by_phase[ph];
        recv_stall_pct = recv_stall_by_phase[ph];
        for (k = 0; k < 28; k++) begin
          if (k == 14) wait_drained();
          send_point(rand_coord(), rand_coord());
        end
      end
    end

    wait_drained();
    repeat (4 * sb.iter_limit + 20) @(posedge clk);
    $display("covered %0d points over %0d register settings, four handshake phases",
             sb.points_seen, settings_count);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
